// ===== rtl/del_pkg.sv =====
// ----------------------------------------------------------------------------
// del_pkg: shared types, constants and helpers
// Pixel and window types, compass masks, register and edge codes, and the
// small arithmetic helpers used by the window cells and the edge evaluator.
// ----------------------------------------------------------------------------
package del_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int MODE_W     = 3;
	localparam int CHAN_W     = 8;
	localparam int KIND_W     = 3;
	localparam int SUM_W      = 12;
	localparam int NUM_DIRS   = 4;
	localparam int WIN_N      = 3;

	localparam int SIZE_MIN = 3;
	localparam int SIZE_RST = 1024;

	localparam logic [CHAN_W-1:0] THRESH_RST = 8'd70;
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

	// divide by three as multiply by reciprocal, exact for sums below 2048
	localparam int GREY_MUL   = 683;
	localparam int GREY_SHIFT = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_THRESH = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] MODE_ALL = 3'd4;

	localparam logic [KIND_W-1:0] EDGE_NONE = 3'd0;
	localparam logic [KIND_W-1:0] EDGE_H    = 3'd1;
	localparam logic [KIND_W-1:0] EDGE_V    = 3'd2;
	localparam logic [KIND_W-1:0] EDGE_D1   = 3'd3;
	localparam logic [KIND_W-1:0] EDGE_D2   = 3'd4;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// index 0 top row, 2 bottom row
	typedef pixel_t [WIN_N-1:0] column_t;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef sum_t [2:0] chan_sums_t;
	typedef chan_sums_t [NUM_DIRS-1:0] dir_sums_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} item_flags_t;

	// horizontal, vertical, diagonal1, diagonal2; row-major 3x3
	localparam logic signed [2:0] MASKS [NUM_DIRS][WIN_N*WIN_N] = '{
		'{-3'sd1, -3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd2,  3'sd1},
		'{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
		'{ 3'sd0,  3'sd1,  3'sd2, -3'sd1,  3'sd0,  3'sd1, -3'sd2, -3'sd1,  3'sd0},
		'{-3'sd2, -3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd1,  3'sd2}
	};

	function automatic logic [CHAN_W-1:0] px_chan(input pixel_t p, input logic [1:0] ch);
		case (ch)
			2'd0: px_chan = p.blue;
			2'd1: px_chan = p.green;
			default: px_chan = p.red;
		endcase
	endfunction

	// one column of one mask applied to one channel
	function automatic sum_t col_sum(input int d, input int k, input column_t c, input int ch);
		sum_t acc;
		acc = '0;
		for (int r = 0; r < WIN_N; r++) begin
			acc += SUM_W'(MASKS[d][r*WIN_N+k]) *
				$signed({{(SUM_W-CHAN_W){1'b0}}, px_chan(c[r], 2'(ch))});
		end
		return acc;
	endfunction

	function automatic logic above_thresh(input sum_t s, input logic [CHAN_W-1:0] thr);
		logic [CHAN_W-1:0] clamped;
		if (s < 0)
			clamped = '0;
		else if (s > $signed(SUM_W'(CHAN_MAX)))
			clamped = CHAN_MAX;
		else
			clamped = s[CHAN_W-1:0];
		return clamped > thr;
	endfunction

	function automatic logic [CHAN_W-1:0] grey_of(input pixel_t p);
		logic [CHAN_W+1:0] total;
		logic [19:0] prod;
		total = (CHAN_W+2)'(p.blue) + (CHAN_W+2)'(p.green) + (CHAN_W+2)'(p.red);
		prod  = 20'(total) * 20'(GREY_MUL);
		return prod[GREY_SHIFT+CHAN_W-1:GREY_SHIFT];
	endfunction

	function automatic pixel_t marker_px(input logic [KIND_W-1:0] kind,
		input logic [CHAN_W-1:0] grey);
		pixel_t p;
		case (kind)
			EDGE_H:  p = '{red: CHAN_MAX, green: '0, blue: '0};
			EDGE_V:  p = '{red: '0, green: '0, blue: CHAN_MAX};
			EDGE_D1: p = '{red: '0, green: CHAN_MAX, blue: '0};
			EDGE_D2: p = '{red: CHAN_MAX, green: CHAN_MAX, blue: '0};
			default: p = '{red: grey, green: grey, blue: grey};
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/del_stream_if.sv =====
// ----------------------------------------------------------------------------
// del_stream_if: pixel and result stream interfaces
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface del_pix_if;
	logic valid;
	logic ready;
	logic [del_pkg::CHAN_W-1:0] blue;
	logic [del_pkg::CHAN_W-1:0] green;
	logic [del_pkg::CHAN_W-1:0] red;

	modport source (output valid, blue, green, red, input ready);
	modport sink (input valid, blue, green, red, output ready);
endinterface

interface del_res_if;
	logic valid;
	logic ready;
	logic [del_pkg::CHAN_W-1:0] out_blue;
	logic [del_pkg::CHAN_W-1:0] out_green;
	logic [del_pkg::CHAN_W-1:0] out_red;
	logic [del_pkg::KIND_W-1:0] edge_kind;
	logic last_pixel;

	modport source (output valid, out_blue, out_green, out_red, edge_kind, last_pixel,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, edge_kind, last_pixel,
		output ready);
endinterface

// ===== rtl/directional_edge_overlay.sv =====
// Path: a transaction passes the stage-1 registers and line memory reads, the window cells,
// the stage-3 registers and the output register. Throughput: one pixel or flush transaction
// per cycle while the output is not stalled and no recompute runs; the first width+1 of a
// frame give none. A write of image_width holds ready low while the shift-subtract divider
// re-splits the frame position into row and column. Reset clears the configuration to its
// defaults, the position and the window; the two line memories are not cleared.
// ----------------------------------------------------------------------------
// directional_edge_overlay: streaming 3x3 compass edge overlay
// Two line memories feed a chain of three window cells; the edge evaluator
// picks a marker colour, otherwise the pixel leaves as grey.
// ----------------------------------------------------------------------------
module directional_edge_overlay #(
	parameter int MAX_WIDTH  = del_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = del_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [del_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [del_pkg::CFG_DATA_W-1:0]    cfg_data,
	del_pix_if.sink                           pix,
	del_res_if.source                         res
);

	localparam int WIDTH_W  = $clog2(MAX_WIDTH+1);
	localparam int HEIGHT_W = $clog2(MAX_HEIGHT+1);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int WIDTH_RST  = (del_pkg::SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : del_pkg::SIZE_RST;
	localparam int HEIGHT_RST = (del_pkg::SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : del_pkg::SIZE_RST;

	// configuration
	logic [del_pkg::MODE_W-1:0] mode_q;
	logic [del_pkg::CHAN_W-1:0] thresh_q;
	logic [WIDTH_W-1:0]         width_q;
	logic [HEIGHT_W-1:0]        height_q;
	logic [WIDTH_W-1:0]         width_wr;
	logic [HEIGHT_W-1:0]        height_wr;
	logic                       restart;

	// handshake and position
	logic                       en;
	logic                       accept;
	logic                       busy;
	logic                       pix_valid;
	logic [COL_W-1:0]           col;
	del_pkg::item_flags_t       flags;
	del_pkg::pixel_t            pix_in;

	// pipeline
	logic                        v_s1;
	del_pkg::pixel_t             pix_s1;
	logic [COL_W-1:0]            col_s1;
	del_pkg::item_flags_t        flags_s1;
	logic                        v_s2;
	del_pkg::item_flags_t        flags_s2;
	logic                        v_s3;
	logic [del_pkg::KIND_W-1:0]  kind_s3;
	logic [del_pkg::CHAN_W-1:0]  grey_s3;
	logic                        last_s3;

	del_pkg::pixel_t             mid_rd;
	del_pkg::pixel_t             top_rd;
	del_pkg::column_t            new_col;
	del_pkg::column_t            cols [del_pkg::WIN_N];
	del_pkg::column_t            chain_in [del_pkg::WIN_N];
	del_pkg::dir_sums_t          parts [del_pkg::WIN_N];
	logic [del_pkg::KIND_W-1:0]  eval_kind;
	logic                        shift;
	del_pkg::pixel_t             out_px;

	always_comb begin
		if (cfg_data < del_pkg::CFG_DATA_W'(del_pkg::SIZE_MIN))
			width_wr = WIDTH_W'(del_pkg::SIZE_MIN);
		else if (32'(cfg_data) > MAX_WIDTH)
			width_wr = WIDTH_W'(MAX_WIDTH);
		else
			width_wr = WIDTH_W'(cfg_data);

		if (cfg_data < del_pkg::CFG_DATA_W'(del_pkg::SIZE_MIN))
			height_wr = HEIGHT_W'(del_pkg::SIZE_MIN);
		else if (32'(cfg_data) > MAX_HEIGHT)
			height_wr = HEIGHT_W'(MAX_HEIGHT);
		else
			height_wr = HEIGHT_W'(cfg_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			thresh_q <= del_pkg::THRESH_RST;
			width_q  <= WIDTH_W'(WIDTH_RST);
			height_q <= HEIGHT_W'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_idx)
				del_pkg::REG_MODE:   mode_q   <= cfg_data[del_pkg::MODE_W-1:0];
				del_pkg::REG_THRESH: thresh_q <= cfg_data[del_pkg::CHAN_W-1:0];
				del_pkg::REG_WIDTH:  width_q  <= width_wr;
				del_pkg::REG_HEIGHT: height_q <= height_wr;
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && cfg_idx == del_pkg::REG_WIDTH;

	// whole pipeline moves when the output register is free
	assign en        = !res.valid || res.ready;
	assign pix.ready = en && !busy;
	assign accept    = pix.valid && pix.ready;

	del_pos_track #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.restart   (restart),
		.width     (width_q),
		.height    (height_q),
		.busy      (busy),
		.pix_valid (pix_valid),
		.col       (col),
		.flags     (flags)
	);

	// flush items push zero
	always_comb begin
		pix_in = '0;
		if (pix_valid)
			pix_in = '{red: pix.red, green: pix.green, blue: pix.blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			res.valid <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && flags_s2.emit;
			res.valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pix_in;
			col_s1   <= col;
			flags_s1 <= flags;
		end
		if (en) begin
			flags_s2       <= flags_s1;
			kind_s3        <= flags_s2.interior ? eval_kind : del_pkg::EDGE_NONE;
			grey_s3        <= del_pkg::grey_of(cols[1][1]);
			last_s3        <= flags_s2.last;
			res.out_blue   <= out_px.blue;
			res.out_green  <= out_px.green;
			res.out_red    <= out_px.red;
			res.edge_kind  <= kind_s3;
			res.last_pixel <= last_s3;
		end
	end

	assign shift = en && v_s1;

	del_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_row_mid (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (mid_rd),
		.wr_en   (shift),
		.wr_addr (col_s1),
		.wr_data (pix_s1)
	);

	// the older row takes what the newer one held at this column
	del_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_row_top (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (top_rd),
		.wr_en   (shift),
		.wr_addr (col_s1),
		.wr_data (mid_rd)
	);

	always_comb begin
		new_col[0]  = top_rd;
		new_col[1]  = mid_rd;
		new_col[2]  = pix_s1;
		chain_in[2] = new_col;
		chain_in[1] = cols[2];
		chain_in[0] = cols[1];
	end

	for (genvar k = 0; k < del_pkg::WIN_N; k++) begin : g_cell
		del_win_cell #(
			.COL (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.col_in (chain_in[k]),
			.col_q  (cols[k]),
			.part   (parts[k])
		);
	end

	del_edge_eval u_eval (
		.part0  (parts[0]),
		.part1  (parts[1]),
		.part2  (parts[2]),
		.thresh (thresh_q),
		.mode   (mode_q),
		.kind   (eval_kind)
	);

	assign out_px = del_pkg::marker_px(kind_s3, grey_s3);

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pix.ready)
		else $error("ready high during position recompute");

	a_grey_plain: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.edge_kind == del_pkg::EDGE_NONE |->
			res.out_blue == res.out_green && res.out_green == res.out_red)
		else $error("non-edge result is not grey");

endmodule

// ===== rtl/del_line_mem.sv =====
// ----------------------------------------------------------------------------
// del_line_mem: one row of pixel history
// Simple dual-port memory with a registered read port.
// ----------------------------------------------------------------------------
module del_line_mem #(
	parameter int DEPTH = del_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output del_pkg::pixel_t          rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  del_pkg::pixel_t          wr_data
);

	del_pkg::pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/del_win_cell.sv =====
// ----------------------------------------------------------------------------
// del_win_cell: one column of the 3x3 window
// Holds three pixels, passes them to the older neighbor on each shift and
// forms this column's share of every mask sum on every channel.
// ----------------------------------------------------------------------------
module del_win_cell #(
	parameter int COL = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  del_pkg::column_t    col_in,
	output del_pkg::column_t    col_q,
	output del_pkg::dir_sums_t  part
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		for (int d = 0; d < del_pkg::NUM_DIRS; d++) begin
			for (int ch = 0; ch < 3; ch++) begin
				part[d][ch] = del_pkg::col_sum(d, COL, col_q, ch);
			end
		end
	end

endmodule

// ===== rtl/del_edge_eval.sv =====
// ----------------------------------------------------------------------------
// del_edge_eval: direction decision
// Adds the column shares, clamps each channel sum and picks the highest-numbered
// enabled direction whose three channels all pass the threshold.
// ----------------------------------------------------------------------------
module del_edge_eval (
	input  del_pkg::dir_sums_t          part0,
	input  del_pkg::dir_sums_t          part1,
	input  del_pkg::dir_sums_t          part2,
	input  logic [del_pkg::CHAN_W-1:0]  thresh,
	input  logic [del_pkg::MODE_W-1:0]  mode,
	output logic [del_pkg::KIND_W-1:0]  kind
);

	always_comb begin
		del_pkg::sum_t total;
		logic hit;
		kind = del_pkg::EDGE_NONE;
		for (int d = 0; d < del_pkg::NUM_DIRS; d++) begin
			hit = 1'b1;
			for (int ch = 0; ch < 3; ch++) begin
				total = $signed(part0[d][ch]) + $signed(part1[d][ch]) + $signed(part2[d][ch]);
				hit = hit & del_pkg::above_thresh(total, thresh);
			end
			// later directions win
			if ((mode == del_pkg::MODE_ALL || mode == del_pkg::MODE_W'(d)) && hit)
				kind = del_pkg::EDGE_H + del_pkg::KIND_W'(d);
		end
	end

endmodule

// ===== rtl/del_pos_track.sv =====
// ----------------------------------------------------------------------------
// del_pos_track: frame position tracker
// Keeps the item position as row and column and derives the per-item flags.
// A width change re-splits the position with a shift-subtract divider.
// ----------------------------------------------------------------------------
module del_pos_track #(
	parameter int MAX_WIDTH  = del_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = del_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
	output logic                              busy,
	output logic                              pix_valid,
	output logic [$clog2(MAX_WIDTH)-1:0]      col,
	output del_pkg::item_flags_t              flags
);

	localparam int WIDTH_W = $clog2(MAX_WIDTH+1);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int POS_W   = $clog2((MAX_HEIGHT+1)*MAX_WIDTH+1);
	localparam int CNT_W   = $clog2(POS_W+1);

	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   dvd_q;
	logic [WIDTH_W-1:0] rem_q;

	logic [WIDTH_W:0]   trial;
	logic               fits;
	logic [WIDTH_W-1:0] rem_next;
	logic [POS_W-1:0]   h_ext;
	logic               col_wrap;
	logic               row_ge2;

	assign h_ext    = POS_W'(height);
	assign row_ge2  = row_q >= POS_W'(2);
	assign col_wrap = (WIDTH_W'(col_q) + WIDTH_W'(1)) == width;

	always_comb begin
		flags.emit     = row_ge2 || (row_q == POS_W'(1) && col_q != '0);
		flags.interior = row_ge2 && row_q < h_ext && col_q >= COL_W'(2);
		flags.last     = row_q > h_ext;
	end

	assign pix_valid = row_q < h_ext;
	assign col       = col_q;
	assign busy      = busy_q;

	// restoring divide step
	assign trial    = {rem_q, dvd_q[POS_W-1]};
	assign fits     = trial >= {1'b0, width};
	assign rem_next = fits ? WIDTH_W'(trial - {1'b0, width}) : trial[WIDTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (restart) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(POS_W);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
				row_q  <= dvd_q;
				col_q  <= rem_q[COL_W-1:0];
			end
		end else if (advance) begin
			if (flags.last) begin
				pos_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			dvd_q <= pos_q;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			dvd_q <= {dvd_q[POS_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	a_no_advance_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !busy_q)
		else $error("item taken while position is being recomputed");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> WIDTH_W'(col_q) < width)
		else $error("column outside the image width");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !restart && flags.last |=> row_q == '0 && col_q == '0 && pos_q == '0)
		else $error("position not cleared after the last item of a frame");

endmodule

// ===== dv/del_overlay_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// del_overlay_checker: result predictor and scoreboard for the edge overlay
// Mirrors the register writes, runs its own line rows, 3x3 window and frame
// position on every accepted pixel transaction, queues the overlay pixel that
// is due, and compares each accepted result transaction field by field.
// ----------------------------------------------------------------------------
module del_overlay_checker #(
	parameter int MAX_W = del_pkg::MAX_WIDTH_DEF,
	parameter int MAX_H = del_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [del_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [del_pkg::CFG_DATA_W-1:0] cfg_data,
	del_pix_if                             pix,
	del_res_if                             res,
	output int                             errors,
	output int                             pending,
	output int                             checked,
	output int                             frames,
	output logic                           at_start
);

	localparam logic [del_pkg::MODE_W-1:0] MODE_H  = 3'd0;
	localparam logic [del_pkg::MODE_W-1:0] MODE_V  = 3'd1;
	localparam logic [del_pkg::MODE_W-1:0] MODE_D1 = 3'd2;
	localparam logic [del_pkg::MODE_W-1:0] MODE_D2 = 3'd3;

	localparam logic [del_pkg::MODE_W-1:0] DIR_MODE [del_pkg::NUM_DIRS] =
		'{MODE_H, MODE_V, MODE_D1, MODE_D2};
	localparam logic [del_pkg::KIND_W-1:0] DIR_KIND [del_pkg::NUM_DIRS] =
		'{del_pkg::EDGE_H, del_pkg::EDGE_V, del_pkg::EDGE_D1, del_pkg::EDGE_D2};

	// row-major 3x3, same direction order as above
	localparam int COMPASS [del_pkg::NUM_DIRS][9] = '{
		'{-1, -2, -1,  0,  0,  0,  1,  2,  1},
		'{-1,  0,  1, -2,  0,  2, -1,  0,  1},
		'{ 0,  1,  2, -1,  0,  1, -2, -1,  0},
		'{-2, -1,  0, -1,  0,  1,  0,  1,  2}
	};

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [7:0]                 b;
		logic [7:0]                 g;
		logic [7:0]                 r;
		logic [del_pkg::KIND_W-1:0] kind;
		logic                       closing;
	} overlay_t;

	logic [del_pkg::MODE_W-1:0]     cur_mode;
	logic [del_pkg::CHAN_W-1:0]     cur_thr;
	logic [del_pkg::CFG_DATA_W-1:0] cur_w;
	logic [del_pkg::CFG_DATA_W-1:0] cur_h;

	// [c] holds the previous row, [MAX_W+c] the row above it
	rgb_t        rows_mem [2*MAX_W];
	rgb_t        win [9];
	int unsigned frame_pos;
	overlay_t    overlay_q [$];

	function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
		if (v < del_pkg::SIZE_MIN)
			return del_pkg::SIZE_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// all three clamped channel sums must clear the threshold
	function automatic bit strong_edge(input int d);
		int s;
		for (int ch = 0; ch < 3; ch++) begin
			s = 0;
			for (int i = 0; i < 9; i++)
				s += COMPASS[d][i] * int'(win[i][8*ch +: 8]);
			if (s < 0)
				s = 0;
			if (s > 255)
				s = 255;
			if (s <= int'(cur_thr))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit predict_overlay(input rgb_t px_in, output overlay_t o);
		int unsigned w, h, area, last_pos, p, c, q, y, x;
		rgb_t px, upper, middle, ctr;
		logic [7:0] grey;
		bit emit;
		w = fit_size(cur_w, MAX_W);
		h = fit_size(cur_h, MAX_H);
		area = w * h;
		last_pos = area + w;
		p = frame_pos;
		px = (p < area) ? px_in : '0;
		c = p % w;
		upper = rows_mem[MAX_W + c];
		middle = rows_mem[c];
		rows_mem[MAX_W + c] = middle;
		rows_mem[c] = px;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3 + 1];
			win[r*3 + 1] = win[r*3 + 2];
		end
		win[2] = upper;
		win[5] = middle;
		win[8] = px;
		o = '0;
		emit = (p >= w + 1);
		if (emit) begin
			q = p - w - 1;
			y = q / w;
			x = q % w;
			ctr = win[4];
			grey = 8'((int'(ctr.b) + int'(ctr.g) + int'(ctr.r)) / 3);
			o.kind = del_pkg::EDGE_NONE;
			if (y >= 1 && y + 1 < h && x >= 1 && x + 1 < w) begin
				for (int d = 0; d < del_pkg::NUM_DIRS; d++) begin
					if ((cur_mode == del_pkg::MODE_ALL || cur_mode == DIR_MODE[d]) &&
						strong_edge(d))
						o.kind = DIR_KIND[d];
				end
			end
			case (o.kind)
				del_pkg::EDGE_H:  {o.b, o.g, o.r} = {8'd0, 8'd0, 8'd255};
				del_pkg::EDGE_V:  {o.b, o.g, o.r} = {8'd255, 8'd0, 8'd0};
				del_pkg::EDGE_D1: {o.b, o.g, o.r} = {8'd0, 8'd255, 8'd0};
				del_pkg::EDGE_D2: {o.b, o.g, o.r} = {8'd0, 8'd255, 8'd255};
				default: {o.b, o.g, o.r} = {grey, grey, grey};
			endcase
			o.closing = (p >= last_pos);
		end
		frame_pos = (p >= last_pos) ? 0 : p + 1;
		return emit;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		overlay_t want;
		if (!arst_n) begin
			cur_mode = MODE_H;
			cur_thr = del_pkg::THRESH_RST;
			cur_w = del_pkg::CFG_DATA_W'(del_pkg::SIZE_RST);
			cur_h = del_pkg::CFG_DATA_W'(del_pkg::SIZE_RST);
			foreach (win[i])
				win[i] = '0;
			foreach (rows_mem[i])
				rows_mem[i] = '0;
			frame_pos = 0;
			overlay_q.delete();
			errors = 0;
			checked = 0;
			frames = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (overlay_q.size() == 0) begin
					$error("result transaction with no pixel awaiting it");
					errors++;
				end else begin
					want = overlay_q.pop_front();
					check_field("out_blue", want.b, res.out_blue);
					check_field("out_green", want.g, res.out_green);
					check_field("out_red", want.r, res.out_red);
					check_field("edge_kind", 8'(want.kind), 8'(res.edge_kind));
					check_field("last_pixel", 8'(want.closing), 8'(res.last_pixel));
					checked++;
					if (want.closing)
						frames++;
				end
			end
			if (cfg_we) begin
				case (del_pkg::cfg_reg_t'(cfg_idx))
					del_pkg::REG_MODE:   cur_mode = cfg_data[del_pkg::MODE_W-1:0];
					del_pkg::REG_THRESH: cur_thr = cfg_data[del_pkg::CHAN_W-1:0];
					del_pkg::REG_WIDTH:  cur_w = cfg_data;
					del_pkg::REG_HEIGHT: cur_h = cfg_data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				if (predict_overlay('{r: pix.red, g: pix.green, b: pix.blue}, want))
					overlay_q.push_back(want);
			end
		end
		pending = overlay_q.size();
		at_start = (frame_pos == 0);
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the directional edge overlay
// Sends whole frames of random pixels under many register settings, with
// random gaps and backpressure, plus frames broken by register changes in
// the middle; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD   = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 420;

	localparam logic [del_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [del_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [del_pkg::CFG_DATA_W-1:0] cfg_data;

	bit   src_calm;
	bit   sink_calm;
	int   pixels_sent;
	int   quiet;
	int   errors;
	int   pending;
	int   checked;
	int   frames;
	logic at_start;

	del_pix_if pix ();
	del_res_if res ();

	directional_edge_overlay dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix      (pix),
		.res      (res)
	);

	del_overlay_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix      (pix),
		.res      (res),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked),
		.frames   (frames),
		.at_start (at_start)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard black/white values make strong gradients; others fill the range
	function automatic logic [7:0] tone();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_item();
		logic [7:0] base;
		int gap;
		base = tone();
		gap = src_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		// half the pixels grey so all three channels tend to agree
		pix.valid <= 1'b1;
		if ($urandom_range(0, 1) == 0) begin
			pix.blue <= base;
			pix.green <= base;
			pix.red <= base;
		end else begin
			pix.blue <= tone();
			pix.green <= tone();
			pix.red <= tone();
		end
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic run_frame();
		do
			push_item();
		while (!at_start);
	endtask

	// hold the sender until every result is out and the pipe has emptied
	task automatic settle();
		pix.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input del_pkg::cfg_reg_t idx,
		input logic [del_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic apply_regs(input logic [del_pkg::MODE_W-1:0] mode, input logic [7:0] thr,
		input logic [del_pkg::CFG_DATA_W-1:0] w, input logic [del_pkg::CFG_DATA_W-1:0] h);
		settle();
		write_reg(del_pkg::REG_MODE, {8'($urandom), mode});
		write_reg(del_pkg::REG_THRESH, {3'($urandom), thr});
		write_reg(del_pkg::REG_HEIGHT, h);
		write_reg(del_pkg::REG_WIDTH, w);
		cfg_we <= 1'b0;
	endtask

	// a short start at a large size, then a small size puts the position
	// past the end so the next transaction closes the frame
	task automatic cut_frame(input int n, input logic [del_pkg::CFG_DATA_W-1:0] w);
		repeat (n) push_item();
		settle();
		write_reg(del_pkg::REG_HEIGHT, del_pkg::CFG_DATA_W'(del_pkg::SIZE_MIN));
		write_reg(del_pkg::REG_WIDTH, w);
		cfg_we <= 1'b0;
		run_frame();
	endtask

	// frame interrupted by one register change once the block is idle
	task automatic broken_frame();
		repeat ($urandom_range(1, 40)) push_item();
		settle();
		case ($urandom_range(0, 3))
			0: write_reg(del_pkg::REG_THRESH,
				del_pkg::CFG_DATA_W'($urandom_range(0, 255)));
			1: write_reg(del_pkg::REG_MODE, del_pkg::CFG_DATA_W'($urandom_range(0, 7)));
			2: write_reg(del_pkg::REG_WIDTH, del_pkg::CFG_DATA_W'($urandom_range(0, 12)));
			default: write_reg(del_pkg::REG_HEIGHT,
				del_pkg::CFG_DATA_W'($urandom_range(0, 8)));
		endcase
		cfg_we <= 1'b0;
		if (!at_start)
			run_frame();
	endtask

	// result side: random stall after each accepted result
	initial begin
		int hold;
		hold = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				hold = sink_calm ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (hold > 0) begin
				res.ready <= 1'b0;
				hold--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		logic [del_pkg::MODE_W-1:0] mode;
		logic [7:0] thr;
		logic [del_pkg::CFG_DATA_W-1:0] w, h;
		int rnd_start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = del_pkg::REG_MODE;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.blue = '0;
		pix.green = '0;
		pix.red = '0;
		pixels_sent = 0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset size and mode, then shrunk mid-frame so the position is re-split
		cut_frame(30, 11'd3);

		// smallest frame, all masks, threshold zero
		apply_regs(del_pkg::MODE_ALL, 8'd0, 11'd3, 11'd3);
		run_frame();
		// unused mode, top threshold, sizes below range
		apply_regs(MODE_SPARE, 8'd255, 11'd2, 11'd1);
		run_frame();
		// sizes above range: clamped to the maximum, frame cut short
		src_calm = 1'b1;
		apply_regs(del_pkg::MODE_ALL, 8'd90, 11'd2047, 11'd2047);
		cut_frame(20, 11'd4);
		src_calm = 1'b0;

		rnd_start = pixels_sent;
		while (pixels_sent - rnd_start < RANDOM_ITEMS) begin
			mode = ($urandom_range(0, 2) == 0) ? del_pkg::MODE_ALL
				: del_pkg::MODE_W'($urandom_range(0, 7));
			case ($urandom_range(0, 7))
				0: thr = 8'd0;
				1: thr = 8'd255;
				default: thr = 8'($urandom_range(0, 200));
			endcase
			w = ($urandom_range(0, 7) == 0) ? del_pkg::CFG_DATA_W'($urandom_range(0, 2))
				: del_pkg::CFG_DATA_W'($urandom_range(3, 9));
			h = ($urandom_range(0, 7) == 0) ? del_pkg::CFG_DATA_W'($urandom_range(0, 2))
				: del_pkg::CFG_DATA_W'($urandom_range(3, 7));
			src_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			apply_regs(mode, thr, w, h);
			if ($urandom_range(0, 4) == 0)
				broken_frame();
			else
				run_frame();
		end

		pix.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("tb_top: %0d pixel/flush transactions sent, %0d results checked, %0d frames",
			pixels_sent, checked, frames);
		$display("tb_top: modes incl. unused, thresholds 0..255, clamped sizes, mid-frame writes");
		if (errors == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
